[hdl/crz_pkg.sv]
// crz_pkg: shared types, codes and width helpers for the circle rasterizer
// no dependencies; used by the front, back and top level
package crz_pkg;

	// input radius field width and job queue depth
	localparam int RADIUS_IN_W = 12;
	localparam int RADIUS_IN_MAX = 4095;
	localparam int QUEUE_DEPTH = 2;

	// command opcodes
	typedef enum logic {
		OP_START = 1'b0,
		OP_STEP  = 1'b1
	} opcode_t;

	// result kinds on the pixel channel
	typedef enum logic [1:0] {
		KIND_POINT = 2'd0,
		KIND_SPAN  = 2'd1,
		KIND_IDLE  = 2'd2
	} res_kind_t;

	// job kinds handed from front to back
	typedef enum logic [1:0] {
		JOB_OUTLINE = 2'd0,
		JOB_FILL    = 2'd1,
		JOB_POINT   = 2'd2,
		JOB_IDLE    = 2'd3
	} job_kind_t;

	// control part of one queued job
	typedef struct packed {
		job_kind_t kind;
		logic      done;
	} job_ctl_t;

	// largest radius kept after saturation
	function automatic int rad_cap(int rmax);
		return (rmax < RADIUS_IN_MAX) ? rmax : RADIUS_IN_MAX;
	endfunction

	// bits of the held radius
	function automatic int rad_width(int rmax);
		return $clog2(rad_cap(rmax) + 1);
	endfunction

	// bits of a signed offset
	function automatic int ofs_width(int rmax);
		return rad_width(rmax) + 1;
	endfunction

	// bits of the signed decision variable
	function automatic int dec_width(int rmax);
		return rad_width(rmax) + 3;
	endfunction

endpackage

[hdl/crz_cmd_if.sv]
// crz_cmd_if: command channel carrying start and step items
// depends on nothing; center widths follow the coordinate width parameter, the radius is 12 bits
interface crz_cmd_if #(
	parameter int CW = 16
);
	logic                 valid;
	logic                 ready;
	logic                 opcode;
	logic signed [CW-1:0] center_x;
	logic signed [CW-1:0] center_y;
	logic [11:0]          radius;
	logic                 filled;

	modport source (
		output valid, opcode, center_x, center_y, radius, filled,
		input  ready
	);

	modport sink (
		input  valid, opcode, center_x, center_y, radius, filled,
		output ready
	);
endinterface

[hdl/crz_pix_if.sv]
// crz_pix_if: result channel carrying points, spans and idle items
// depends on nothing; widths follow the coordinate width parameter
interface crz_pix_if #(
	parameter int CW = 16
);
	logic               valid;
	logic               ready;
	logic [1:0]         kind;
	logic signed [CW:0] x_first;
	logic signed [CW:0] x_last;
	logic signed [CW:0] row;
	logic               last_of_step;
	logic               circle_done;

	modport source (
		output valid, kind, x_first, x_last, row, last_of_step, circle_done,
		input  ready
	);

	modport sink (
		input  valid, kind, x_first, x_last, row, last_of_step, circle_done,
		output ready
	);
endinterface

[hdl/crz_fifo.sv]
// crz_fifo: small register queue of packed jobs between front and back
// depends on nothing; width and depth are parameters
module crz_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             head_valid,
	output logic [WIDTH-1:0] head_data
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [NW-1:0]    count_q;

	assign full       = (count_q == NW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_data  = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + NW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

	// fill count stays in range
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= NW'(DEPTH)) else $error("queue count out of range");

	// no write into a full queue
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("queue overrun");

	// no read from an empty queue
	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid) else $error("queue underrun");

endmodule

[hdl/crz_front.sv]
// crz_front: accepts command items, keeps the circle state, runs at most one
// Andres circle iteration per item and queues a job; uses crz_pkg
module crz_front #(
	parameter int CW = 16,
	parameter int RADIUS_MAX = 4095
) (
	input  logic                clk,
	input  logic                arst_n,
	crz_cmd_if.sink             cmd,
	input  logic                q_full,
	output logic                push,
	output crz_pkg::job_ctl_t   job_ctl,
	output logic signed [CW-1:0] job_cx,
	output logic signed [CW-1:0] job_cy,
	output logic signed [crz_pkg::ofs_width(RADIUS_MAX)-1:0] job_a,
	output logic signed [crz_pkg::ofs_width(RADIUS_MAX)-1:0] job_b
);
	localparam int RCAP = crz_pkg::rad_cap(RADIUS_MAX);
	localparam int RW = crz_pkg::rad_width(RADIUS_MAX);
	localparam int OW = crz_pkg::ofs_width(RADIUS_MAX);
	localparam int DW = crz_pkg::dec_width(RADIUS_MAX);
	localparam int EW = DW + 1;

	// circle state
	logic signed [CW-1:0] cx_q;
	logic signed [CW-1:0] cy_q;
	logic [RW-1:0]        rad_q;
	logic                 fill_q;
	logic signed [OW-1:0] a_q;
	logic signed [OW-1:0] b_q;
	logic signed [DW-1:0] dec_q;
	logic                 active_q;

	logic                 accept;
	logic                 is_start;
	logic [RW-1:0]        r_sat;
	logic                 tiny_rad;
	logic signed [OW-1:0] it_a;
	logic signed [OW-1:0] it_b;
	logic signed [DW-1:0] it_d;
	logic [RW-1:0]        it_r;
	logic signed [OW-1:0] a_next;
	logic signed [OW-1:0] b_next;
	logic signed [DW-1:0] d_next;
	logic                 active_next;

	assign cmd.ready = !q_full;
	assign accept    = cmd.valid && cmd.ready;
	assign push      = accept;
	assign is_start  = (cmd.opcode == crz_pkg::OP_START);

	// radius saturation
	always_comb begin
		if (cmd.radius > (crz_pkg::RADIUS_IN_W)'(RCAP)) begin
			r_sat = RW'(RCAP);
		end else begin
			r_sat = cmd.radius[RW-1:0];
		end
	end
	assign tiny_rad = (r_sat <= RW'(1));

	// iteration operands: fresh circle or held state
	always_comb begin
		if (is_start) begin
			it_a = '0;
			it_b = $signed({1'b0, r_sat});
			it_d = $signed({3'b000, r_sat} - DW'(1));
			it_r = r_sat;
		end else begin
			it_a = a_q;
			it_b = b_q;
			it_d = dec_q;
			it_r = rad_q;
		end
	end

	// Andres circle decision update
	always_comb begin
		logic signed [EW-1:0] a_e;
		logic signed [EW-1:0] b_e;
		logic signed [EW-1:0] d_e;
		logic signed [EW-1:0] r_e;
		logic signed [EW-1:0] d_w;
		a_e = EW'(it_a);
		b_e = EW'(it_b);
		d_e = EW'(it_d);
		r_e = $signed({(EW - RW)'(0), it_r});
		priority if (d_e >= (a_e <<< 1)) begin
			d_w    = d_e - (a_e <<< 1) - EW'(1);
			a_next = it_a + OW'(1);
			b_next = it_b;
		end else if (d_e < ((r_e - b_e) <<< 1)) begin
			d_w    = d_e + (b_e <<< 1) - EW'(1);
			a_next = it_a;
			b_next = it_b - OW'(1);
		end else begin
			d_w    = d_e + ((b_e - a_e - EW'(1)) <<< 1);
			a_next = it_a + OW'(1);
			b_next = it_b - OW'(1);
		end
		d_next = d_w[DW-1:0];
	end
	assign active_next = (b_next >= a_next);

	// job description for the back part
	always_comb begin
		job_cx = is_start ? cmd.center_x : cx_q;
		job_cy = is_start ? cmd.center_y : cy_q;
		job_a  = it_a;
		job_b  = it_b;
		priority if (is_start && tiny_rad) begin
			job_ctl.kind = crz_pkg::JOB_POINT;
			job_ctl.done = 1'b1;
			job_a        = '0;
			job_b        = '0;
		end else if (!is_start && !active_q) begin
			job_ctl.kind = crz_pkg::JOB_IDLE;
			job_ctl.done = 1'b0;
		end else begin
			job_ctl.kind = (is_start ? cmd.filled : fill_q) ?
				crz_pkg::JOB_FILL : crz_pkg::JOB_OUTLINE;
			job_ctl.done = !active_next;
		end
	end

	// state update on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q     <= '0;
			cy_q     <= '0;
			rad_q    <= '0;
			fill_q   <= 1'b0;
			a_q      <= '0;
			b_q      <= '0;
			dec_q    <= '0;
			active_q <= 1'b0;
		end else if (accept) begin
			if (is_start) begin
				cx_q   <= cmd.center_x;
				cy_q   <= cmd.center_y;
				rad_q  <= r_sat;
				fill_q <= cmd.filled;
			end
			if (is_start && tiny_rad) begin
				a_q      <= '0;
				b_q      <= '0;
				dec_q    <= '0;
				active_q <= 1'b0;
			end else if (is_start || active_q) begin
				a_q      <= a_next;
				b_q      <= b_next;
				dec_q    <= d_next;
				active_q <= active_next;
			end
		end
	end

endmodule

[hdl/crz_back.sv]
// crz_back: expands queued jobs into points, spans and idle results, one result per
// cycle unless the output stalls, behind an output register; uses crz_pkg and crz_pix_if
module crz_back #(
	parameter int CW = 16,
	parameter int RADIUS_MAX = 4095
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                job_valid,
	input  crz_pkg::job_ctl_t   job_ctl,
	input  logic signed [CW-1:0] job_cx,
	input  logic signed [CW-1:0] job_cy,
	input  logic signed [crz_pkg::ofs_width(RADIUS_MAX)-1:0] job_a,
	input  logic signed [crz_pkg::ofs_width(RADIUS_MAX)-1:0] job_b,
	output logic                pop,
	crz_pix_if.source           pix
);
	localparam int OW = crz_pkg::ofs_width(RADIUS_MAX);
	localparam int SW = ((CW > OW) ? CW : OW) + 2;

	// job being expanded
	logic                 cur_valid_q;
	crz_pkg::job_ctl_t    cur_ctl_q;
	logic signed [CW-1:0] cur_cx_q;
	logic signed [CW-1:0] cur_cy_q;
	logic signed [OW-1:0] cur_a_q;
	logic signed [OW-1:0] cur_b_q;
	logic [2:0]           idx_q;

	// output register
	logic                 o_valid_q;
	crz_pkg::res_kind_t   o_kind_q;
	logic signed [CW:0]   o_xf_q;
	logic signed [CW:0]   o_xl_q;
	logic signed [CW:0]   o_row_q;
	logic                 o_last_q;
	logic                 o_done_q;

	logic                 adv;
	logic                 is_last;
	logic [2:0]           last_idx;
	crz_pkg::res_kind_t   r_kind;
	logic signed [CW:0]   r_xf;
	logic signed [CW:0]   r_xl;
	logic signed [CW:0]   r_row;

	// results per job kind
	always_comb begin
		unique case (cur_ctl_q.kind)
			crz_pkg::JOB_OUTLINE: last_idx = 3'd7;
			crz_pkg::JOB_FILL:    last_idx = 3'd3;
			crz_pkg::JOB_POINT:   last_idx = 3'd0;
			crz_pkg::JOB_IDLE:    last_idx = 3'd0;
			default:              last_idx = 3'd0;
		endcase
	end
	assign is_last = (idx_q == last_idx);
	assign adv     = cur_valid_q && (!o_valid_q || pix.ready);
	assign pop     = job_valid && (!cur_valid_q || (adv && is_last));

	// coordinates of the current result
	always_comb begin
		logic                 swap;
		logic                 xneg;
		logic                 yneg;
		logic signed [SW-1:0] cx_e;
		logic signed [SW-1:0] cy_e;
		logic signed [SW-1:0] px_e;
		logic signed [SW-1:0] py_e;
		logic signed [SW-1:0] x_plus;
		logic signed [SW-1:0] x_minus;
		logic signed [SW-1:0] y_sel;
		swap = (cur_ctl_q.kind == crz_pkg::JOB_FILL) ? idx_q[1] : idx_q[0];
		xneg = idx_q[1];
		yneg = (cur_ctl_q.kind == crz_pkg::JOB_FILL) ? idx_q[0] : idx_q[2];
		cx_e = SW'(cur_cx_q);
		cy_e = SW'(cur_cy_q);
		px_e = swap ? SW'(cur_b_q) : SW'(cur_a_q);
		py_e = swap ? SW'(cur_a_q) : SW'(cur_b_q);
		x_plus  = cx_e + px_e;
		x_minus = cx_e - px_e;
		y_sel   = yneg ? (cy_e - py_e) : (cy_e + py_e);
		unique case (cur_ctl_q.kind)
			crz_pkg::JOB_OUTLINE: begin
				r_kind = crz_pkg::KIND_POINT;
				r_xf   = xneg ? x_minus[CW:0] : x_plus[CW:0];
				r_xl   = r_xf;
				r_row  = y_sel[CW:0];
			end
			crz_pkg::JOB_FILL: begin
				r_kind = crz_pkg::KIND_SPAN;
				r_xf   = x_minus[CW:0];
				r_xl   = x_plus[CW:0];
				r_row  = y_sel[CW:0];
			end
			crz_pkg::JOB_POINT: begin
				r_kind = crz_pkg::KIND_POINT;
				r_xf   = cx_e[CW:0];
				r_xl   = cx_e[CW:0];
				r_row  = cy_e[CW:0];
			end
			default: begin
				r_kind = crz_pkg::KIND_IDLE;
				r_xf   = '0;
				r_xl   = '0;
				r_row  = '0;
			end
		endcase
	end

	// current job and result index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			cur_ctl_q   <= '{kind: crz_pkg::JOB_IDLE, done: 1'b0};
			idx_q       <= '0;
		end else begin
			if (pop) begin
				cur_valid_q <= 1'b1;
				cur_ctl_q   <= job_ctl;
				idx_q       <= '0;
			end else if (adv) begin
				if (is_last) begin
					cur_valid_q <= 1'b0;
				end
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	// job payload
	always_ff @(posedge clk) begin
		if (pop) begin
			cur_cx_q <= job_cx;
			cur_cy_q <= job_cy;
			cur_a_q  <= job_a;
			cur_b_q  <= job_b;
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_valid_q <= 1'b0;
		end else if (!o_valid_q || pix.ready) begin
			o_valid_q <= cur_valid_q;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (adv) begin
			o_kind_q <= r_kind;
			o_xf_q   <= r_xf;
			o_xl_q   <= r_xl;
			o_row_q  <= r_row;
			o_last_q <= is_last;
			o_done_q <= cur_ctl_q.done;
		end
	end

	assign pix.valid        = o_valid_q;
	assign pix.kind         = o_kind_q;
	assign pix.x_first      = o_xf_q;
	assign pix.x_last       = o_xl_q;
	assign pix.row          = o_row_q;
	assign pix.last_of_step = o_last_q;
	assign pix.circle_done  = o_done_q;

	// idle results close their item and never finish a circle
	a_idle_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(o_valid_q && o_kind_q == crz_pkg::KIND_IDLE) |-> (o_last_q && !o_done_q))
		else $error("idle result with bad flags");

	// single-result jobs never advance past the first index
	a_single_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(cur_valid_q && (cur_ctl_q.kind == crz_pkg::JOB_POINT ||
		cur_ctl_q.kind == crz_pkg::JOB_IDLE)) |-> (idx_q == 3'd0))
		else $error("single-result job advanced");

	// a stalled result stays offered and unchanged
	a_hold_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(o_valid_q && !pix.ready) |=> (o_valid_q &&
		$stable({o_kind_q, o_xf_q, o_xl_q, o_row_q, o_last_q, o_done_q})))
		else $error("stalled result changed");

endmodule

[hdl/circle_rasterizer.sv]
// Path: an accepted item goes through the job queue, the back's job registers
// and the output register. Throughput: the front takes one item per cycle while
// its two-entry job queue has room; the back emits one result per cycle unless pix
// stalls; outline items give 8 results, filled 4, small-radius or idle 1.
// Reset: asynchronous, clears the circle state (no circle active), queue, current job and output valid.
module circle_rasterizer #(
	parameter int COORD_WIDTH = 16,
	parameter int RADIUS_MAX = 4095
) (
	input  logic      clk,
	input  logic      arst_n,
	crz_cmd_if.sink   cmd,
	crz_pix_if.source pix
);
	localparam int OW = crz_pkg::ofs_width(RADIUS_MAX);
	localparam int JW = $bits(crz_pkg::job_ctl_t) + 2 * COORD_WIDTH + 2 * OW;

	logic                          push;
	logic                          q_full;
	logic                          pop;
	logic                          q_valid;
	logic [JW-1:0]                 q_wdata;
	logic [JW-1:0]                 q_rdata;
	crz_pkg::job_ctl_t             f_ctl;
	logic signed [COORD_WIDTH-1:0] f_cx;
	logic signed [COORD_WIDTH-1:0] f_cy;
	logic signed [OW-1:0]          f_a;
	logic signed [OW-1:0]          f_b;
	crz_pkg::job_ctl_t             b_ctl;
	logic signed [COORD_WIDTH-1:0] b_cx;
	logic signed [COORD_WIDTH-1:0] b_cy;
	logic signed [OW-1:0]          b_a;
	logic signed [OW-1:0]          b_b;

	// front: accept and iterate
	crz_front #(
		.CW(COORD_WIDTH),
		.RADIUS_MAX(RADIUS_MAX)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.q_full(q_full),
		.push(push),
		.job_ctl(f_ctl),
		.job_cx(f_cx),
		.job_cy(f_cy),
		.job_a(f_a),
		.job_b(f_b)
	);

	// job queue
	assign q_wdata = {f_ctl, f_cx, f_cy, f_a, f_b};
	assign {b_ctl, b_cx, b_cy, b_a, b_b} = q_rdata;

	crz_fifo #(
		.WIDTH(JW),
		.DEPTH(crz_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(q_wdata),
		.full(q_full),
		.pop(pop),
		.head_valid(q_valid),
		.head_data(q_rdata)
	);

	// back: expand jobs into results
	crz_back #(
		.CW(COORD_WIDTH),
		.RADIUS_MAX(RADIUS_MAX)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.job_valid(q_valid),
		.job_ctl(b_ctl),
		.job_cx(b_cx),
		.job_cy(b_cy),
		.job_a(b_a),
		.job_b(b_b),
		.pop(pop),
		.pix(pix)
	);

endmodule
